// ===== rtl/sfa_pkg.sv =====
// Shared types and constants for the swap frame allocator.
// Holds the transfer payload structs, controller command and status, and state codes.
// No dependencies.
`default_nettype none

package sfa_pkg;

    localparam int SPACE_W      = 6;
    localparam int PAGE_INDEX_W = 20;
    localparam int FLAGS_W      = 12;
    localparam int FRAME_W      = 4;
    localparam int OWNER_PAGE_W = 5;
    localparam int WORD_W       = 32;
    localparam int PAGE_SHIFT   = 12;

    localparam logic [FLAGS_W-1:0] FLAG_MASK = 12'hfff;
    localparam logic [FLAGS_W-1:0] DIRTY_BIT = 12'h400;
    localparam logic [FLAGS_W-1:0] VALID_BIT = 12'h200;
    localparam logic [WORD_W-1:0]  ADDR_MASK = 32'hfffff000;

    localparam logic KIND_EVICT = 1'b0;
    localparam logic KIND_LOAD  = 1'b1;

    typedef struct packed {
        logic [SPACE_W-1:0]      address_space;
        logic [PAGE_INDEX_W-1:0] page_index;
        logic [FLAGS_W-1:0]      entry_low_flags;
    } fault_t;

    typedef struct packed {
        logic                    kind;
        logic [FRAME_W-1:0]      frame;
        logic [SPACE_W-1:0]      owner_space;
        logic [OWNER_PAGE_W-1:0] owner_page;
        logic [WORD_W-1:0]       entry_low;
        logic                    last;
    } result_t;

    typedef struct packed {
        logic capture;
        logic show_load;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic pool_full;
    } dp_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVICT,
        ST_LOAD
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/sfa_datapath.sv =====
// Datapath of the swap frame allocator: fill count, round-robin pointer, owner table.
// Builds eviction and load results under commands from sfa_ctrl.
// Depends on sfa_pkg.
`default_nettype none

module sfa_datapath
    import sfa_pkg::*;
#(
    parameter int POOL_FRAMES = 16,
    parameter int PAGE_LIMIT  = 32
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [WORD_W-1:0]  cfg_wr_data,
    input  wire fault_t             s_data,
    input  wire ctrl_cmd_t          cmd,
    output dp_status_t              status,
    output result_t                 m_data
);

    localparam int FW = $clog2(POOL_FRAMES);
    localparam int CW = $clog2(POOL_FRAMES + 1);
    localparam int PW = $clog2(PAGE_LIMIT);
    localparam logic [CW-1:0]           POOL_COUNT = CW'(POOL_FRAMES);
    localparam logic [FW-1:0]           LAST_FRAME = FW'(POOL_FRAMES - 1);
    localparam logic [PAGE_INDEX_W-1:0] PAGE_LIMIT_W = PAGE_INDEX_W'(PAGE_LIMIT);
    localparam logic [PW-1:0]           PAGE_MAX = PW'(PAGE_LIMIT - 1);

    logic [WORD_W-1:0]  pool_base_reg;
    logic [CW-1:0]      fill_reg, fill_next;
    logic [FW-1:0]      victim_reg, victim_next;
    logic [FW-1:0]      chosen_reg, chosen_next;
    logic [SPACE_W-1:0] space_reg;
    logic [PW-1:0]      page_reg, page_next;
    logic [FLAGS_W-1:0] flags_reg;
    logic [SPACE_W-1:0] ev_space_reg;
    logic [PW-1:0]      ev_page_reg;

    logic [SPACE_W-1:0] owner_space_mem [POOL_FRAMES];
    logic [PW-1:0]      owner_page_mem  [POOL_FRAMES];

    logic [WORD_W-PAGE_SHIFT-1:0] addr_hi;
    logic [FLAGS_W-1:0]           low_flags;
    logic [WORD_W-1:0]            load_word;

    assign status.pool_full = (fill_reg == POOL_COUNT);

    always_comb begin
        chosen_next = status.pool_full ? victim_reg : fill_reg[FW-1:0];
        victim_next = (chosen_next == LAST_FRAME) ? '0 : chosen_next + FW'(1);
        fill_next   = status.pool_full ? fill_reg : fill_reg + CW'(1);
        if (s_data.page_index >= PAGE_LIMIT_W) begin
            page_next = PAGE_MAX;
        end else begin
            page_next = s_data.page_index[PW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_base_reg <= '0;
            fill_reg      <= '0;
            victim_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                pool_base_reg <= cfg_wr_data;
            end
            if (cmd.capture) begin
                fill_reg   <= fill_next;
                victim_reg <= victim_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            chosen_reg <= chosen_next;
            space_reg  <= s_data.address_space;
            page_reg   <= page_next;
            flags_reg  <= s_data.entry_low_flags;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            ev_space_reg <= owner_space_mem[chosen_next];
            ev_page_reg  <= owner_page_mem[chosen_next];
        end
        if (cmd.commit) begin
            owner_space_mem[chosen_reg] <= space_reg;
            owner_page_mem[chosen_reg]  <= page_reg;
        end
    end

    always_comb begin
        addr_hi   = pool_base_reg[WORD_W-1:PAGE_SHIFT] + (WORD_W - PAGE_SHIFT)'(chosen_reg);
        low_flags = (flags_reg | DIRTY_BIT | VALID_BIT) & FLAG_MASK;
        load_word = ({addr_hi, {PAGE_SHIFT{1'b0}}} & ADDR_MASK) | WORD_W'(low_flags);

        m_data.frame = FRAME_W'(chosen_reg);
        if (cmd.show_load) begin
            m_data.kind        = KIND_LOAD;
            m_data.owner_space = space_reg;
            m_data.owner_page  = OWNER_PAGE_W'(page_reg);
            m_data.entry_low   = load_word;
            m_data.last        = 1'b1;
        end else begin
            m_data.kind        = KIND_EVICT;
            m_data.owner_space = ev_space_reg;
            m_data.owner_page  = OWNER_PAGE_W'(ev_page_reg);
            m_data.entry_low   = '0;
            m_data.last        = 1'b0;
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= POOL_COUNT)
        else $error("fill count exceeds pool size");

    a_fill_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture && !status.pool_full |=> fill_reg == $past(fill_reg) + CW'(1))
        else $error("fill count did not advance on a free-frame fault");

    a_full_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        status.pool_full |=> status.pool_full)
        else $error("pool left the full condition");

endmodule

`default_nettype wire

// ===== rtl/sfa_ctrl.sv =====
// Controller state machine of the swap frame allocator.
// Sequences capture, optional eviction transfer and load transfer; drives the datapath.
// Depends on sfa_pkg.
`default_nettype none

module sfa_ctrl
    import sfa_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  wire logic       m_ready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        s_ready       = 1'b0;
        m_valid       = 1'b0;
        cmd.capture   = 1'b0;
        cmd.show_load = 1'b0;
        cmd.commit    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = status.pool_full ? ST_EVICT : ST_LOAD;
                end
            end
            ST_EVICT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                m_valid       = 1'b1;
                cmd.show_load = 1'b1;
                cmd.commit    = m_ready;
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg != ST_IDLE)
        else $error("accepted fault left the controller idle");

    a_free_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture && !status.pool_full |=> state_reg == ST_LOAD)
        else $error("eviction issued while a free frame existed");

    a_evict_then_load: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EVICT && m_ready |=> state_reg == ST_LOAD)
        else $error("eviction transfer not followed by load");

    a_load_done: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LOAD && m_ready |=> state_reg == ST_IDLE)
        else $error("controller did not return to idle after load");

endmodule

`default_nettype wire

// ===== rtl/swap_frame_allocator.sv =====
// Top level of the swap frame allocator: page fault in, eviction and load results out.
// Instantiates sfa_ctrl and sfa_datapath; depends on sfa_pkg.
//
// Each accepted page fault picks the lowest free frame of the pool, or the frame at a
// round-robin pointer once every frame is owned, and produces an eviction transfer (only
// when the frame was owned) followed by a load transfer marked last. The eviction
// transfer has a state of its own, ST_EVICT ahead of ST_LOAD, since the owner-table read
// of the evicted entry is registered at the accepting edge. Both transfers wait while the
// result side holds m_ready low and otherwise leave one per cycle. Faults are taken one
// at a time.
// The pool base address may be written only while no fault is in flight.
`default_nettype none

module swap_frame_allocator
    import sfa_pkg::*;
#(
    parameter int POOL_FRAMES = 16,
    parameter int PAGE_LIMIT  = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [WORD_W-1:0] cfg_wr_data,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire fault_t            s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output result_t                m_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    sfa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sfa_datapath #(
        .POOL_FRAMES (POOL_FRAMES),
        .PAGE_LIMIT  (PAGE_LIMIT)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .cmd         (cmd),
        .status      (status),
        .m_data      (m_data)
    );

endmodule

`default_nettype wire

// ===== sim/tb_swap_frame_allocator.sv =====
// Self-checking testbench for swap_frame_allocator: page faults in, eviction and load
// transfers out, checked against a frame-table model kept inside the scoreboard class.
// Depends on sfa_pkg and the swap_frame_allocator RTL.
`timescale 1ns / 1ps

module tb_swap_frame_allocator
    import sfa_pkg::*;
();

    localparam int POOL_FRAMES = 16;
    localparam int PAGE_LIMIT  = 32;
    localparam int FRAME_BYTES = 4096;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;

    class frame_table_model;
        logic [WORD_W-1:0]       pool_base;
        bit                      frame_taken [POOL_FRAMES];
        logic [SPACE_W-1:0]      taken_space [POOL_FRAMES];
        logic [PAGE_INDEX_W-1:0] taken_page  [POOL_FRAMES];
        int                      victim_ptr;
        result_t                 owed_transfers [$];
        int                      mismatches;

        function new();
            pool_base  = '0;
            victim_ptr = 0;
            mismatches = 0;
            for (int i = 0; i < POOL_FRAMES; i++) begin
                frame_taken[i] = 1'b0;
                taken_space[i] = '0;
                taken_page[i]  = '0;
            end
        endfunction

        function void set_pool_base(logic [WORD_W-1:0] value);
            pool_base = value;
        endfunction

        function int pending();
            return owed_transfers.size();
        endfunction

        function void note_fault(fault_t f);
            logic [PAGE_INDEX_W-1:0] page;
            logic [WORD_W-1:0]       addr;
            logic [FLAGS_W-1:0]      flags;
            result_t                 r;
            int                      chosen;
            bit                      found;
            page   = (f.page_index >= PAGE_LIMIT) ? PAGE_INDEX_W'(PAGE_LIMIT - 1) : f.page_index;
            chosen = victim_ptr;
            found  = 1'b0;
            for (int i = 0; i < POOL_FRAMES; i++) begin
                if (!found && !frame_taken[i]) begin
                    chosen = i;
                    found  = 1'b1;
                end
            end
            victim_ptr = (chosen + 1) % POOL_FRAMES;
            if (frame_taken[chosen]) begin
                r.kind        = KIND_EVICT;
                r.frame       = FRAME_W'(chosen);
                r.owner_space = taken_space[chosen];
                r.owner_page  = taken_page[chosen][OWNER_PAGE_W-1:0];
                r.entry_low   = '0;
                r.last        = 1'b0;
                owed_transfers.push_back(r);
            end
            frame_taken[chosen] = 1'b1;
            taken_space[chosen] = f.address_space;
            taken_page[chosen]  = page;
            addr  = pool_base + WORD_W'(chosen) * WORD_W'(FRAME_BYTES);
            flags = (f.entry_low_flags | DIRTY_BIT | VALID_BIT) & FLAG_MASK;
            r.kind        = KIND_LOAD;
            r.frame       = FRAME_W'(chosen);
            r.owner_space = f.address_space;
            r.owner_page  = page[OWNER_PAGE_W-1:0];
            r.entry_low   = (addr & ADDR_MASK) | WORD_W'(flags);
            r.last        = 1'b1;
            owed_transfers.push_back(r);
        endfunction

        function void check_transfer(result_t got);
            result_t want;
            if (owed_transfers.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: unexpected result transfer %h", got);
                return;
            end
            want = owed_transfers.pop_front();
            if (got.kind !== want.kind || got.frame !== want.frame
                    || got.owner_space !== want.owner_space
                    || got.owner_page !== want.owner_page
                    || got.entry_low !== want.entry_low || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"ERROR: result mismatch kind %b/%b frame %h/%h space %h/%h ",
                              "page %h/%h entry_low %h/%h last %b/%b (expected/actual)"},
                             want.kind, got.kind, want.frame, got.frame,
                             want.owner_space, got.owner_space, want.owner_page,
                             got.owner_page, want.entry_low, got.entry_low,
                             want.last, got.last);
            end
        endfunction
    endclass

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [WORD_W-1:0] cfg_wr_data = '0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    fault_t            s_data      = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    result_t           m_data;

    frame_table_model sb = new();
    int               source_idle_pct = 0;
    int               sink_idle_pct   = 0;
    int               cycle_count     = 0;

    swap_frame_allocator #(
        .POOL_FRAMES(POOL_FRAMES),
        .PAGE_LIMIT (PAGE_LIMIT)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_swap_frame_allocator NOT OK");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note_fault(s_data);
        if (aresetn && m_valid && m_ready)
            sb.check_transfer(m_data);
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    function automatic fault_t make_fault(int space, int page, int flags);
        fault_t f;
        f.address_space   = SPACE_W'(space);
        f.page_index      = PAGE_INDEX_W'(page);
        f.entry_low_flags = FLAGS_W'(flags);
        return f;
    endfunction

    function automatic fault_t random_fault();
        int pick;
        int page;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            page = $urandom_range(0, PAGE_LIMIT - 1);
        else if (pick < 85)
            page = $urandom_range(PAGE_LIMIT, PAGE_LIMIT + 3);
        else
            page = $urandom_range(0, (1 << PAGE_INDEX_W) - 1);
        return make_fault($urandom_range(0, 63), page, $urandom_range(0, 4095));
    endfunction

    task automatic send_fault(input fault_t f);
        if (source_idle_pct != 0 && $urandom_range(0, 99) < source_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= f;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_pool_base(input logic [WORD_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_pool_base(value);
        @(posedge aclk);
    endtask

    task automatic run_phase(input logic [WORD_W-1:0] base, input int count,
                             input int src_pct, input int snk_pct);
        drain_results();
        write_pool_base(base);
        source_idle_pct = src_pct;
        sink_idle_pct   = snk_pct;
        for (int i = 0; i < count; i++)
            send_fault(random_fault());
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // The top of the pool wraps past the end of the address space here.
        write_pool_base(32'hFFFFF000);
        source_idle_pct = 20;
        sink_idle_pct   = 20;
        send_fault(make_fault(0, 0, 12'h000));
        send_fault(make_fault(63, 31, 12'hfff));
        send_fault(make_fault(1, 32, 12'h555));
        send_fault(make_fault(62, 20'hfffff, 12'haaa));
        send_fault(make_fault(6'h2a, 5'h15, 12'h9ff));
        send_fault(make_fault(6'h15, 5'h0a, 12'h600));
        send_fault(make_fault(5, 33, 12'h001));
        send_fault(make_fault(10, 1000, 12'h800));
        for (int i = 0; i < 8; i++)
            send_fault(make_fault(i * 8 + 3, i * 4, i * 12'h111));
        send_fault(make_fault(63, 0, 12'hfff));
        send_fault(make_fault(0, 31, 12'h000));
        send_fault(make_fault(33, 20'h80000, 12'h3ff));
        send_fault(make_fault(7, 16, 12'h400));

        run_phase(32'h00000000, 200, 25, 25);
        run_phase(32'hFFFFFFFF, 200, 40, 10);
        run_phase(32'h00000FFF, 200, 0, 0);
        run_phase($urandom(), 200, 15, 40);
        run_phase($urandom() & ADDR_MASK, 200, 30, 30);
        run_phase($urandom(), 200, 0, 0);

        drain_results();
        repeat (2) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb_swap_frame_allocator OK");
        end else begin
            $display("tb_swap_frame_allocator NOT OK");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/sfa_pkg.sv
rtl/sfa_datapath.sv
rtl/sfa_ctrl.sv
rtl/swap_frame_allocator.sv
sim/tb_swap_frame_allocator.sv
